// ===== hdl/tscc_pkg.sv =====
// ---------------------------------------------------------------------------
// Thermal sensor calibrate and convert: shared definitions
// Transfer types, register indices, command and status codes, and the
// factory default first calibration point of each sensor.
// ---------------------------------------------------------------------------
package tscc_pkg;

   localparam int SENSOR_COUNT_DEFAULT = 11;

   // Configuration register indices.
   localparam logic [1:0] CSR_CAL_MODE = 2'd0;
   localparam logic [1:0] CSR_BASE_ONE = 2'd1;
   localparam logic [1:0] CSR_BASE_TWO = 2'd2;

   // Calibration modes; every other code selects the factory defaults.
   localparam logic [2:0] MODE_ONE_POINT     = 3'd1;
   localparam logic [2:0] MODE_ONE_POINT_ALT = 3'd2;
   localparam logic [2:0] MODE_TWO_POINT     = 3'd3;

   localparam logic CMD_CALIBRATE = 1'b0;
   localparam logic CMD_CONVERT   = 1'b1;

   localparam logic [1:0] STATUS_CONVERTED  = 2'd0;
   localparam logic [1:0] STATUS_CALIBRATED = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SLOPE = 2'd2;

   // Second calibration point used in one-point mode and when no fuse calibration is present.
   localparam logic [10:0] DEFAULT_POINT_TWO = 11'd780;

   // Two-point slope is (p2 - p1) * 1000 / 90.
   localparam logic [31:0] TWO_POINT_SPAN = 32'd90;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  sensor_index;
      logic [5:0]  raw_point_one;
      logic [5:0]  raw_point_two;
      logic [15:0] given_slope;
      logic [9:0]  sensor_code;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature;
      logic [1:0]         status;
   } rsp_type;

   function automatic logic [10:0] default_point_one(input logic [3:0] index);
      logic [10:0] point;
      unique case (index)
         4'd0:    point = 11'd502;
         4'd1:    point = 11'd509;
         4'd2:    point = 11'd503;
         4'd3:    point = 11'd509;
         4'd4:    point = 11'd505;
         4'd5:    point = 11'd509;
         4'd6:    point = 11'd507;
         4'd7:    point = 11'd510;
         4'd8:    point = 11'd508;
         4'd9:    point = 11'd509;
         4'd10:   point = 11'd508;
         default: point = 11'd0;
      endcase
      return point;
   endfunction

endpackage

// ===== hdl/thermal_sensor_calibrate_convert.sv =====
// ---------------------------------------------------------------------------
// Thermal sensor calibrate and convert
// Per-sensor linear calibration store and conversion of a ten-bit sensor
// code to degrees C, built around one shared 32-bit signed divider.
// ---------------------------------------------------------------------------
// Usage: an item is transferred on req_data at a clock edge where start is
// high and busy is low. A calibrate command stores a slope and an offset for
// the addressed sensor; a convert command turns sensor_code into degrees C.
// Exactly one result follows each item: rsp_valid is high for one cycle with
// rsp_data, and the receiver must take it then, as it cannot stall.
// A calibrate outside two-point mode passes SETUP and OFFSET; a zero-slope
// convert or a calibrate of an index past the last sensor ends in SETUP;
// a two-point calibrate passes SETUP, PREP, DIV, FINISH and OFFSET, a normal
// convert SETUP, ROUND, PREP, DIV and FINISH. The restoring divider in DIV
// retires one quotient bit a cycle for all 32 bits. busy is high for the
// whole item, so one item is in work at a time; the next may be transferred
// in the cycle the strobe shows. The user must write cal_mode, base_one and
// base_two through the csr_ port only while busy is low; the block does not
// enforce this. Synchronous reset clears the registers and every stored
// slope and offset, so an uncalibrated sensor reads as zero slope.
// ---------------------------------------------------------------------------
module thermal_sensor_calibrate_convert #(
   parameter int SENSOR_COUNT = tscc_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tscc_pkg::req_type req_data,
   output logic              rsp_valid,
   output tscc_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data
);
   import tscc_pkg::*;

   localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETUP  = 7'b0000010,
      ST_ROUND  = 7'b0000100,
      ST_PREP   = 7'b0001000,
      ST_DIV    = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_OFFSET = 7'b1000000
   } state_type;

   function automatic logic [31:0] times_1000(input logic [31:0] x);
      return (x << 10) - (x << 5) + (x << 3);
   endfunction

   function automatic logic [31:0] times_30(input logic [31:0] x);
      return (x << 5) - (x << 1);
   endfunction

   function automatic logic [31:0] magnitude(input logic [31:0] x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [2:0]  cal_mode_ff;
   logic [7:0]  base_one_ff;
   logic [7:0]  base_two_ff;
   logic [31:0] slope_tbl_ff  [SENSOR_COUNT];
   logic [31:0] offset_tbl_ff [SENSOR_COUNT];

   logic [31:0] num_ff, num_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] p1k_ff, p1k_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             in_range;
   logic [IDX_W-1:0] idx;
   logic [10:0]      point_one;
   logic [10:0]      point_two;
   logic [31:0]      point_diff;
   logic [31:0]      stored_slope;
   logic [31:0]      half_den;
   logic [32:0]      shifted;
   logic [32:0]      trial;
   logic [31:0]      quotient;
   logic             tbl_we;
   logic [31:0]      tbl_offset;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_range     = ({28'd0, req_ff.sensor_index} < 32'(SENSOR_COUNT));
   assign idx          = req_ff.sensor_index[IDX_W-1:0];
   assign stored_slope = in_range ? slope_tbl_ff[idx] : 32'd0;

   // Calibration points from the fuse offsets and the shared bases, or the factory defaults.
   always_comb begin
      priority if (cal_mode_ff == MODE_ONE_POINT) begin
         point_one = {5'd0, req_ff.raw_point_one} + {1'b0, base_one_ff, 2'b11};
         point_two = DEFAULT_POINT_TWO;
      end else if (cal_mode_ff == MODE_ONE_POINT_ALT ||
                   cal_mode_ff == MODE_TWO_POINT) begin
         point_one = {({3'd0, req_ff.raw_point_one} + {1'b0, base_one_ff}), 2'b11};
         point_two = {({3'd0, req_ff.raw_point_two} + {1'b0, base_two_ff}), 2'b11};
      end else begin
         point_one = default_point_one(req_ff.sensor_index);
         point_two = DEFAULT_POINT_TWO;
      end
   end

   assign point_diff = {21'd0, point_two} - {21'd0, point_one};

   // Half the divisor, truncated towards zero.
   assign half_den = $signed(den_ff + {31'd0, den_ff[31]}) >>> 1;

   assign shifted  = {rem_ff, quo_ff[31]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

   assign tbl_offset = p1k_ff - times_30(den_ff);

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      p1k_in       = p1k_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      tbl_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (req_ff.cmd == CMD_CALIBRATE) begin
               p1k_in = times_1000({21'd0, point_one});
               if (!in_range) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.temperature = '0;
                  rsp_data_in.status      = STATUS_CALIBRATED;
                  state_in                = ST_IDLE;
               end else if (cal_mode_ff == MODE_TWO_POINT) begin
                  num_in   = times_1000(point_diff);
                  den_in   = TWO_POINT_SPAN;
                  state_in = ST_PREP;
               end else begin
                  den_in   = {16'd0, req_ff.given_slope};
                  state_in = ST_OFFSET;
               end
            end else begin
               if (stored_slope == 32'd0) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.temperature = '0;
                  rsp_data_in.status      = STATUS_ZERO_SLOPE;
                  state_in                = ST_IDLE;
               end else begin
                  den_in   = stored_slope;
                  num_in   = times_1000({22'd0, req_ff.sensor_code}) - offset_tbl_ff[idx];
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            // Round half away from zero ahead of the truncating divide, when the slope is positive.
            priority if (num_ff == 32'd0) begin
               num_in = 32'd0;
            end else if (num_ff[31]) begin
               num_in = num_ff - half_den;
            end else begin
               num_in = num_ff + half_den;
            end
            state_in = ST_PREP;
         end
         ST_PREP: begin
            rem_in   = 32'd0;
            quo_in   = magnitude(num_ff);
            dvs_in   = magnitude(den_ff);
            neg_in   = num_ff[31] ^ den_ff[31];
            cnt_in   = 5'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (req_ff.cmd == CMD_CALIBRATE) begin
               den_in   = quotient;
               state_in = ST_OFFSET;
            end else begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.temperature = quotient;
               rsp_data_in.status      = STATUS_CONVERTED;
               state_in                = ST_IDLE;
            end
         end
         ST_OFFSET: begin
            tbl_we                  = 1'b1;
            rsp_valid_in            = 1'b1;
            rsp_data_in.temperature = '0;
            rsp_data_in.status      = STATUS_CALIBRATED;
            state_in                = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cal_mode_ff  <= '0;
         base_one_ff  <= '0;
         base_two_ff  <= '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            slope_tbl_ff[i]  <= '0;
            offset_tbl_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_CAL_MODE: cal_mode_ff <= csr_write_data[2:0];
               CSR_BASE_ONE: base_one_ff <= csr_write_data;
               CSR_BASE_TWO: base_two_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (tbl_we) begin
            slope_tbl_ff[idx]  <= den_ff;
            offset_tbl_ff[idx] <= tbl_offset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      num_ff      <= num_in;
      den_ff      <= den_in;
      p1k_ff      <= p1k_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
